>>> sv/uniform_step_interp_lookup_macros.svh
// Assertion macros shared by the interpolation lookup RTL.
`ifndef UNIFORM_STEP_INTERP_LOOKUP_MACROS_SVH
`define UNIFORM_STEP_INTERP_LOOKUP_MACROS_SVH

// Same-cycle implication, clocked on clk, off while rst_n is low.
`define USIL_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off while rst_n is low.
`define USIL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/usil_pkg.sv
// Package: types, widths, codes and divider step functions of the lookup block.
`timescale 1ns / 1ps
package usil_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 256;

    localparam int X_W        = 16;
    localparam int STEP_W     = 8;
    localparam int CNT_W      = 8;
    localparam int IDX_W      = 8;
    localparam int Y_W        = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_X_START      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_STEP       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_USED = 2'd2;

    localparam logic KIND_LOOKUP = 1'b0;
    localparam logic KIND_WRITE  = 1'b1;

    localparam int IDX_STAGES     = 4;
    localparam int IDX_BITS_PER   = IDX_W / IDX_STAGES;
    localparam int SLOPE_STAGES   = 4;
    localparam int SLOPE_BITS_PER = Y_W / SLOPE_STAGES;

    typedef logic signed [Y_W-1:0] sample_t;

    typedef struct packed {
        logic              wr;
        logic [IDX_W-1:0]  widx;
        sample_t           wval;
        logic              below;
        logic              interp;
        logic [CNT_W-1:0]  last;
        logic [STEP_W-1:0] step;
        logic [X_W-1:0]    span;
        logic [X_W-1:0]    rem;
        logic [IDX_W-1:0]  q;
    } front_t;

    typedef struct packed {
        logic              interp;
        logic [STEP_W-1:0] rem;
        logic [STEP_W-1:0] step;
        sample_t           base;
        logic              neg;
        logic [Y_W-1:0]    num;
        logic [STEP_W-1:0] r;
    } back_t;

    // One restoring step of the index divide: returns {quotient bit, new remainder}.
    function automatic logic [X_W:0] usil_idx_step(input logic [X_W-1:0] r,
                                                   input logic [STEP_W-1:0] s,
                                                   input int unsigned sh);
        logic [X_W-1:0] d;
        d = {{(X_W-STEP_W){1'b0}}, s} << sh;
        if (r >= d)
            return {1'b1, r - d};
        else
            return {1'b0, r};
    endfunction

    // One restoring step of the slope divide: returns {new remainder, shifted numerator}.
    function automatic logic [STEP_W+Y_W-1:0] usil_slope_step(input logic [STEP_W-1:0] r,
                                                              input logic [Y_W-1:0] num,
                                                              input logic [STEP_W-1:0] s);
        logic [STEP_W:0] t;
        logic [STEP_W:0] d;
        t = {r, num[Y_W-1]};
        d = t - {1'b0, s};
        if (t >= {1'b0, s})
            return {d[STEP_W-1:0], num[Y_W-2:0], 1'b1};
        else
            return {t[STEP_W-1:0], num[Y_W-2:0], 1'b0};
    endfunction

endpackage

>>> sv/usil_ifs.sv
// Interfaces: command, result and configuration channels of the lookup block.
`timescale 1ns / 1ps
interface usil_in_if import usil_pkg::*; ();
    logic             valid;
    logic             ready;
    logic             kind;
    logic [X_W-1:0]   x_in;
    logic [IDX_W-1:0] entry_index;
    sample_t          entry_value;

    modport source (output valid, kind, x_in, entry_index, entry_value, input ready);
    modport sink   (input valid, kind, x_in, entry_index, entry_value, output ready);
endinterface

interface usil_out_if import usil_pkg::*; ();
    logic    valid;
    logic    ready;
    sample_t y_out;

    modport source (output valid, y_out, input ready);
    modport sink   (input valid, y_out, output ready);
endinterface

interface usil_cfg_if import usil_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> sv/usil_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module usil_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/uniform_step_interp_lookup.sv
// Top level: pipelined uniform-step linear interpolation table lookup.
//
// Channels: cmd takes one beat per item; kind selects a lookup of x_in or a
// write of entry_value at entry_index. rsp returns y_out for each lookup; a
// write returns no beat. cfg writes x_start, x_step and entries_used by index
// and is always ready; write it only while no item is in flight.
// Throughput: one item per cycle while rsp takes its beats. A lookup result
// passes through the input stage, four index-divide stages, the table read,
// the difference stage, four slope-divide stages, the multiply and the output
// register. Table writes land at the table read stage, so writes and lookups
// take effect in order.
// Reset: config returns to x_start 0, x_step 1, entries_used 1 and the pipeline
// empties; table contents stay undefined until written.
// Stall: the whole pipeline holds while rsp has a beat that is not taken, and
// cmd.ready drops in the same cycle; nothing is lost or repeated.
`timescale 1ns / 1ps
`include "uniform_step_interp_lookup_macros.svh"
module uniform_step_interp_lookup import usil_pkg::*; #(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    usil_cfg_if.sink   cfg,
    usil_in_if.sink    cmd,
    usil_out_if.source rsp
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    logic [X_W-1:0]    x_start_reg;
    logic [STEP_W-1:0] x_step_reg;
    logic [CNT_W-1:0]  entries_used_reg;

    logic adv;

    logic   fv_reg [0:IDX_STAGES];
    front_t fr_reg [0:IDX_STAGES];

    logic              rd_v_reg;
    logic              rd_interp_reg;
    logic [STEP_W-1:0] rd_rem_reg;
    logic [STEP_W-1:0] rd_step_reg;

    logic   bv_reg [0:SLOPE_STAGES];
    back_t  br_reg [0:SLOPE_STAGES];

    logic           mul_v_reg;
    logic           mul_interp_reg;
    logic           mul_neg_reg;
    sample_t        mul_base_reg;
    logic [Y_W-1:0] mul_prod_reg;

    logic    out_v_reg;
    sample_t y_reg;

    logic [ADDR_W-1:0] addr_a;
    logic [ADDR_W-1:0] addr_b;
    logic              ram_we;
    logic [Y_W-1:0]    ram_a_q;
    logic [Y_W-1:0]    ram_b_q;

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_start_reg      <= '0;
            x_step_reg       <= STEP_W'(1);
            entries_used_reg <= CNT_W'(1);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_X_START:      x_start_reg      <= cfg.data;
                REG_X_STEP:       x_step_reg       <= cfg.data[STEP_W-1:0];
                REG_ENTRIES_USED: entries_used_reg <= cfg.data[CNT_W-1:0];
                default:          ;
            endcase
        end
    end

    // Global advance: hold everything while a result waits
    assign adv       = !out_v_reg || rsp.ready;
    assign cmd.ready = adv;

    // Input stage
    logic [STEP_W-1:0] step_eff;
    logic [CNT_W-1:0]  last_c;
    front_t            in_next;

    always_comb
    begin
        step_eff = (x_step_reg == '0) ? STEP_W'(1) : x_step_reg;
        if (entries_used_reg == '0)
            last_c = '0;
        else if (32'(entries_used_reg) > TABLE_DEPTH)
            last_c = CNT_W'(TABLE_DEPTH - 1);
        else
            last_c = entries_used_reg - CNT_W'(1);

        in_next        = '0;
        in_next.wr     = (cmd.kind == KIND_WRITE);
        in_next.widx   = cmd.entry_index;
        in_next.wval   = cmd.entry_value;
        in_next.below  = (cmd.x_in < x_start_reg);
        in_next.last   = last_c;
        in_next.step   = step_eff;
        in_next.span   = X_W'({{(X_W-STEP_W){1'b0}}, step_eff}
                              * {{(X_W-CNT_W){1'b0}}, last_c});
        in_next.rem    = cmd.x_in - x_start_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fv_reg[0] <= 1'b0;
        else if (adv)
            fv_reg[0] <= cmd.valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            fr_reg[0] <= in_next;
    end

    // Index divide: offset / step, quotient bits MSB first
    for (genvar k = 1; k <= IDX_STAGES; k++)
    begin : g_idx
        front_t nxt;
        logic [X_W:0] st;

        always_comb
        begin
            nxt = fr_reg[k-1];
            st  = '0;
            if (k == 1)
                nxt.interp = !fr_reg[0].below && (fr_reg[0].rem < fr_reg[0].span);
            for (int j = 0; j < IDX_BITS_PER; j++)
            begin
                st = usil_idx_step(nxt.rem, nxt.step,
                                   IDX_W - 1 - (k - 1) * IDX_BITS_PER - j);
                nxt.rem = st[X_W-1:0];
                if (st[X_W])
                    nxt.q = nxt.q | (IDX_W'(1) << (IDX_W - 1 - (k - 1) * IDX_BITS_PER - j));
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                fv_reg[k] <= 1'b0;
            else if (adv)
                fv_reg[k] <= fv_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                fr_reg[k] <= nxt;
        end
    end

    // Table read and write stage
    always_comb
    begin
        if (fr_reg[IDX_STAGES].below)
            addr_a = '0;
        else if (fr_reg[IDX_STAGES].interp)
            addr_a = ADDR_W'(fr_reg[IDX_STAGES].q);
        else
            addr_a = ADDR_W'(fr_reg[IDX_STAGES].last);
        addr_b = ADDR_W'({1'b0, fr_reg[IDX_STAGES].q} + (IDX_W + 1)'(1));
        ram_we = adv && fv_reg[IDX_STAGES] && fr_reg[IDX_STAGES].wr
                 && (32'(fr_reg[IDX_STAGES].widx) < TABLE_DEPTH);
    end

    usil_ram #(
        .WIDTH (Y_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram_a (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ADDR_W'(fr_reg[IDX_STAGES].widx)),
        .wdata (fr_reg[IDX_STAGES].wval),
        .re    (adv),
        .raddr (addr_a),
        .rdata (ram_a_q)
    );

    usil_ram #(
        .WIDTH (Y_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram_b (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ADDR_W'(fr_reg[IDX_STAGES].widx)),
        .wdata (fr_reg[IDX_STAGES].wval),
        .re    (adv),
        .raddr (addr_b),
        .rdata (ram_b_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rd_v_reg <= 1'b0;
        else if (adv)
            rd_v_reg <= fv_reg[IDX_STAGES] && !fr_reg[IDX_STAGES].wr;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rd_interp_reg <= fr_reg[IDX_STAGES].interp;
            rd_rem_reg    <= fr_reg[IDX_STAGES].rem[STEP_W-1:0];
            rd_step_reg   <= fr_reg[IDX_STAGES].step;
        end
    end

    // Neighbor difference, split into sign and magnitude
    logic signed [Y_W:0] diff;
    back_t               diff_next;

    always_comb
    begin
        diff = {ram_b_q[Y_W-1], ram_b_q} - {ram_a_q[Y_W-1], ram_a_q};
        diff_next        = '0;
        diff_next.interp = rd_interp_reg;
        diff_next.rem    = rd_rem_reg;
        diff_next.step   = rd_step_reg;
        diff_next.base   = ram_a_q;
        diff_next.neg    = diff[Y_W];
        diff_next.num    = diff[Y_W] ? Y_W'(-diff) : diff[Y_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bv_reg[0] <= 1'b0;
        else if (adv)
            bv_reg[0] <= rd_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            br_reg[0] <= diff_next;
    end

    // Slope divide: |difference| / step
    for (genvar k = 1; k <= SLOPE_STAGES; k++)
    begin : g_slope
        back_t nxt;
        logic [STEP_W+Y_W-1:0] st;

        always_comb
        begin
            nxt = br_reg[k-1];
            st  = '0;
            for (int j = 0; j < SLOPE_BITS_PER; j++)
            begin
                st      = usil_slope_step(nxt.r, nxt.num, nxt.step);
                nxt.r   = st[STEP_W+Y_W-1:Y_W];
                nxt.num = st[Y_W-1:0];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                bv_reg[k] <= 1'b0;
            else if (adv)
                bv_reg[k] <= bv_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
                br_reg[k] <= nxt;
        end
    end

    // Slope magnitude times remainder
    logic [Y_W+STEP_W-1:0] prod_full;

    assign prod_full = br_reg[SLOPE_STAGES].num * br_reg[SLOPE_STAGES].rem;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mul_v_reg <= 1'b0;
        else if (adv)
            mul_v_reg <= bv_reg[SLOPE_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mul_interp_reg <= br_reg[SLOPE_STAGES].interp;
            mul_neg_reg    <= br_reg[SLOPE_STAGES].neg;
            mul_base_reg   <= br_reg[SLOPE_STAGES].base;
            mul_prod_reg   <= prod_full[Y_W-1:0];
        end
    end

    // Output register
    logic [Y_W-1:0] term;
    sample_t        y_next;

    always_comb
    begin
        term   = mul_neg_reg ? (~mul_prod_reg + Y_W'(1)) : mul_prod_reg;
        y_next = mul_interp_reg ? sample_t'(mul_base_reg + term) : mul_base_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (adv)
            out_v_reg <= mul_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            y_reg <= y_next;
    end

    assign rsp.valid = out_v_reg;
    assign rsp.y_out = y_reg;

    `USIL_ASSERT_IMPL(a_idx_in_range, fv_reg[IDX_STAGES] && !fr_reg[IDX_STAGES].wr && fr_reg[IDX_STAGES].interp, fr_reg[IDX_STAGES].q < fr_reg[IDX_STAGES].last, "interpolation index beyond last entry")
    `USIL_ASSERT_IMPL(a_idx_rem, fv_reg[IDX_STAGES] && !fr_reg[IDX_STAGES].wr && fr_reg[IDX_STAGES].interp, fr_reg[IDX_STAGES].rem < X_W'(fr_reg[IDX_STAGES].step), "index remainder not below step")
    `USIL_ASSERT_IMPL(a_slope_rem, bv_reg[SLOPE_STAGES] && br_reg[SLOPE_STAGES].interp, br_reg[SLOPE_STAGES].r < br_reg[SLOPE_STAGES].step, "slope remainder not below step")
    `USIL_ASSERT_IMPL(a_out_source, $rose(out_v_reg), $past(adv && mul_v_reg), "result without a lookup behind it")
    `USIL_ASSERT_NEXT(a_stall_hold, out_v_reg && !rsp.ready, fv_reg[0] == $past(fv_reg[0]), "input stage moved during stall")

endmodule

>>> bench/tb.sv
// Testbench for uniform_step_interp_lookup: directed table, random phases, shadow-model check.
`timescale 1ns / 1ps
module tb;
    import usil_pkg::*;

    localparam int TABLE_DEPTH   = DEFAULT_TABLE_DEPTH;
    localparam int ADDR_W        = $clog2(TABLE_DEPTH);
    localparam int LATENCY       = 12;
    localparam int SETTLE_CYCLES = LATENCY + 4;
    localparam int HOLD_CYCLES   = 150;
    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 100;
    localparam int STALL_ITEMS   = 60;
    localparam int MAX_REPORTS   = 10;
    localparam int DIR_ROWS      = 27;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef enum logic [1:0] {ROW_WRITE, ROW_LOOKUP, ROW_REG} row_kind_t;
    typedef enum logic [1:0] {SINK_OPEN, SINK_BUSY, SINK_CHOKED} sink_mode_t;

    typedef struct packed {
        row_kind_t        what;
        logic [X_W-1:0]   x;
        logic [IDX_W-1:0] idx;
        logic [Y_W-1:0]   val;
        logic             known;
        logic [Y_W-1:0]   y;
    } stim_row_t;

    logic clk;
    logic rst_n;

    usil_in_if  cmd_if ();
    usil_out_if rsp_if ();
    usil_cfg_if cfg_if ();

    uniform_step_interp_lookup uut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_if),
        .cmd   (cmd_if),
        .rsp   (rsp_if)
    );

    logic [X_W-1:0]    cur_x_start;
    logic [STEP_W-1:0] cur_step;
    logic [CNT_W-1:0]  cur_entries;
    sample_t           shadow_table [TABLE_DEPTH];
    sample_t           y_expected [$];

    int mismatches = 0;
    int hold_seq   = 0;
    bit no_gaps;
    int burst_left;

    stim_row_t dir_rows [DIR_ROWS] = '{
        '{ROW_WRITE,  16'h0000, 8'd0,                    16'h7FFF, 1'b0, 16'h0000},
        '{ROW_LOOKUP, 16'h0000, 8'd0,                    16'h0000, 1'b1, 16'h7FFF},
        '{ROW_LOOKUP, 16'hFFFF, 8'hFF,                   16'hFFFF, 1'b1, 16'h7FFF},
        '{ROW_WRITE,  16'hFFFF, 8'd0,                    16'h8000, 1'b0, 16'h0000},
        '{ROW_LOOKUP, 16'h1234, 8'd0,                    16'h0000, 1'b1, 16'h8000},
        '{ROW_WRITE,  16'h0000, 8'd1,                    16'h7FFF, 1'b0, 16'h0000},
        '{ROW_WRITE,  16'h0000, 8'hFF,                   16'h5A5A, 1'b0, 16'h0000},
        '{ROW_REG,    16'h0000, IDX_W'(REG_ENTRIES_USED), 16'h0002, 1'b0, 16'h0000},
        '{ROW_LOOKUP, 16'h0000, 8'd0,                    16'h0000, 1'b1, 16'h8000},
        '{ROW_LOOKUP, 16'h0001, 8'd0,                    16'h0000, 1'b1, 16'h7FFF},
        '{ROW_REG,    16'h0000, IDX_W'(REG_X_STEP),       16'h00FF, 1'b0, 16'h0000},
        '{ROW_LOOKUP, 16'd254,  8'd0,                    16'h0000, 1'b0, 16'h0000},
        '{ROW_LOOKUP, 16'd255,  8'd0,                    16'h0000, 1'b1, 16'h7FFF},
        '{ROW_REG,    16'h0000, IDX_W'(REG_X_START),      16'hFFFF, 1'b0, 16'h0000},
        '{ROW_LOOKUP, 16'hFFFE, 8'd0,                    16'h0000, 1'b1, 16'h8000},
        '{ROW_LOOKUP, 16'hFFFF, 8'd0,                    16'h0000, 1'b1, 16'h8000},
        '{ROW_REG,    16'h0000, IDX_W'(REG_X_START),      16'h0000, 1'b0, 16'h0000},
        '{ROW_REG,    16'h0000, IDX_W'(REG_X_STEP),       16'hFF00, 1'b0, 16'h0000},
        '{ROW_LOOKUP, 16'h0001, 8'd0,                    16'h0000, 1'b1, 16'h7FFF},
        '{ROW_WRITE,  16'h0000, 8'd0,                    16'h0000, 1'b0, 16'h0000},
        '{ROW_WRITE,  16'h0000, 8'd1,                    16'hFFFF, 1'b0, 16'h0000},
        '{ROW_REG,    16'h0000, IDX_W'(REG_X_STEP),       16'h0002, 1'b0, 16'h0000},
        '{ROW_LOOKUP, 16'h0001, 8'd0,                    16'h0000, 1'b0, 16'h0000},
        '{ROW_REG,    16'h0000, IDX_W'(REG_ENTRIES_USED), 16'hFF00, 1'b0, 16'h0000},
        '{ROW_LOOKUP, 16'hFFFF, 8'd0,                    16'h0000, 1'b1, 16'h0000},
        '{ROW_REG,    16'h0000, IDX_W'(REG_UNUSED),       16'hFFFF, 1'b0, 16'h0000},
        '{ROW_LOOKUP, 16'h0000, 8'd0,                    16'h0000, 1'b1, 16'h0000}
    };

    function automatic sample_t interp_value(input logic [X_W-1:0] x);
        int unsigned stp;
        int unsigned last;
        int unsigned norm;
        int unsigned span;
        int unsigned pos;
        int unsigned rem;
        int          base;
        int          slope;
        int          sum;
        stp  = (cur_step == 0) ? 1 : cur_step;
        last = (cur_entries == 0) ? 0 : cur_entries - 1;
        if (last > TABLE_DEPTH - 1)
            last = TABLE_DEPTH - 1;
        if (x < cur_x_start)
            return shadow_table[0];
        norm = x - cur_x_start;
        span = stp * last;
        if (norm >= span)
            return shadow_table[ADDR_W'(last)];
        pos   = norm / stp;
        rem   = norm - pos * stp;
        base  = shadow_table[ADDR_W'(pos)];
        slope = (int'(shadow_table[ADDR_W'(pos + 1)]) - base) / int'(stp);
        sum   = base + slope * int'(rem);
        return sum[Y_W-1:0];
    endfunction

    function automatic logic [X_W-1:0] pick_x();
        int          stp;
        int          last;
        int          span;
        int          lo;
        int          v;
        int unsigned pick;
        stp  = (cur_step == 0) ? 1 : cur_step;
        last = (cur_entries == 0) ? 0 : cur_entries - 1;
        span = stp * last;
        lo   = cur_x_start;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            v = lo + $urandom_range(0, span);
        else if (pick < 65)
        begin
            case ($urandom_range(0, 4))
                0: v = lo - 1;
                1: v = lo;
                2: v = lo + span - 1;
                3: v = lo + span;
                default: v = lo + stp * $urandom_range(0, last);
            endcase
        end
        else if (pick < 80)
            v = (lo == 0) ? $urandom_range(0, 65535) : $urandom_range(0, lo - 1);
        else
            v = $urandom_range(0, 65535);
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        return v[X_W-1:0];
    endfunction

    task automatic apply_item(input logic kind, input logic [X_W-1:0] x,
                              input logic [IDX_W-1:0] idx, input logic [Y_W-1:0] val,
                              input logic known, input logic [Y_W-1:0] y);
        int gap;
        cmd_if.valid       <= 1'b1;
        cmd_if.kind        <= kind;
        cmd_if.x_in        <= x;
        cmd_if.entry_index <= idx;
        cmd_if.entry_value <= val;
        do
            @(posedge clk);
        while (cmd_if.ready !== 1'b1);
        if (kind == KIND_WRITE)
        begin
            if (idx < TABLE_DEPTH)
                shadow_table[idx] = val;
        end
        else
            y_expected.push_back(known ? sample_t'(y) : interp_value(x));
        if (!no_gaps)
        begin
            if (burst_left > 0)
                burst_left--;
            else
            begin
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                burst_left = $urandom_range(1, 40);
                if (gap > 0)
                begin
                    cmd_if.valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    endtask

    task automatic settle();
        cmd_if.valid <= 1'b0;
        while (y_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        do
            @(posedge clk);
        while (cfg_if.ready !== 1'b1);
        case (idx)
            REG_X_START:      cur_x_start = data;
            REG_X_STEP:       cur_step    = data[STEP_W-1:0];
            REG_ENTRIES_USED: cur_entries = data[CNT_W-1:0];
            default: ;
        endcase
        cfg_if.valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAIL uniform_step_interp_lookup");
        $finish;
    end

    initial
    begin : result_check
        int         hold_left;
        int         hold_seen;
        int         mode_left;
        sink_mode_t mode;
        sample_t    want;
        rsp_if.ready = 1'b0;
        hold_left    = 0;
        hold_seen    = 0;
        mode_left    = 0;
        mode         = SINK_OPEN;
        forever
        begin
            @(posedge clk);
            if (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)
            begin
                if (y_expected.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected beat: y_out %0d with nothing pending", rsp_if.y_out);
                end
                else
                begin
                    want = y_expected.pop_front();
                    if (rsp_if.y_out !== want)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("y_out mismatch: expected %0d, got %0d", want, rsp_if.y_out);
                    end
                end
            end
            if (hold_seen != hold_seq)
            begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = sink_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(5, 60);
                end
                mode_left--;
                case (mode)
                    SINK_OPEN: rsp_if.ready <= 1'b1;
                    SINK_BUSY: rsp_if.ready <= ($urandom_range(0, 3) != 0);
                    default:   rsp_if.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    initial
    begin : stimulus
        int                    ph;
        int                    n;
        logic [CFG_DATA_W-1:0] s;
        logic [CFG_DATA_W-1:0] st;
        logic [CFG_DATA_W-1:0] en;
        rst_n              = 1'b0;
        cmd_if.valid       = 1'b0;
        cmd_if.kind        = KIND_LOOKUP;
        cmd_if.x_in        = '0;
        cmd_if.entry_index = '0;
        cmd_if.entry_value = '0;
        cfg_if.valid       = 1'b0;
        cfg_if.index       = REG_X_START;
        cfg_if.data        = '0;
        cur_x_start        = '0;
        cur_step           = 8'd1;
        cur_entries        = 8'd1;
        no_gaps            = 1'b0;
        burst_left         = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            case (dir_rows[i].what)
                ROW_REG:
                begin
                    settle();
                    write_reg(dir_rows[i].idx[CFG_IDX_W-1:0], dir_rows[i].val);
                end
                ROW_WRITE:
                    apply_item(KIND_WRITE, dir_rows[i].x, dir_rows[i].idx, dir_rows[i].val,
                               1'b0, '0);
                default:
                    apply_item(KIND_LOOKUP, dir_rows[i].x, dir_rows[i].idx, dir_rows[i].val,
                               dir_rows[i].known, dir_rows[i].y);
            endcase
        end

        // populate every entry before random lookups
        for (n = 0; n < TABLE_DEPTH; n++)
            apply_item(KIND_WRITE, X_W'($urandom), IDX_W'(n), Y_W'($urandom), 1'b0, '0);

        for (ph = 0; ph < PHASES; ph++)
        begin
            settle();
            case (ph)
                0: begin s = 16'h0000; st = 16'h0001; en = 16'h00FF; end
                1: begin s = 16'hFFFF; st = 16'h00FF; en = 16'h00FF; end
                2: begin s = 16'h0000; st = 16'h00FF; en = 16'h00FF; end
                3: begin s = 16'd12345; st = 16'd37; en = 16'd200; end
                4: begin s = 16'h4000; st = 16'hAB00; en = 16'h5600; end
                default:
                begin
                    s  = CFG_DATA_W'($urandom);
                    st = CFG_DATA_W'($urandom);
                    en = CFG_DATA_W'($urandom);
                end
            endcase
            write_reg(REG_X_START, s);
            write_reg(REG_X_STEP, st);
            write_reg(REG_ENTRIES_USED, en);
            if (ph == 3)
                write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
            if (ph == 2 || ph == 6)
            begin
                // hold the result side and keep offering lookups back to back
                hold_seq <= hold_seq + 1;
                no_gaps = 1'b1;
                for (n = 0; n < STALL_ITEMS; n++)
                    apply_item(KIND_LOOKUP, pick_x(), IDX_W'($urandom), Y_W'($urandom),
                               1'b0, '0);
                no_gaps = 1'b0;
            end
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 99) < 15)
                    apply_item(KIND_WRITE, X_W'($urandom), IDX_W'($urandom), Y_W'($urandom),
                               1'b0, '0);
                else
                    apply_item(KIND_LOOKUP, pick_x(), IDX_W'($urandom), Y_W'($urandom),
                               1'b0, '0);
            end
        end

        settle();
        if (mismatches == 0)
            $display("PASS uniform_step_interp_lookup");
        else
            $display("FAIL uniform_step_interp_lookup");
        $finish;
    end

endmodule
